### hdl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types, codes and the microcode table of the retire ring.
// ----------------------------------------------------------------------------
package grr_pkg;

   localparam int DEF_SLOT_COUNT      = 16;
   localparam int DEF_HANDLE_BITS     = 32;
   localparam int DEF_GENERATION_BITS = 32;

   localparam int GRACE_BITS = 16;
   localparam logic [GRACE_BITS-1:0] GRACE_RESET = 16'd2;

   // action codes
   localparam logic [1:0] ACT_RETIRE  = 2'd0;
   localparam logic [1:0] ACT_ADVANCE = 2'd1;
   localparam logic [1:0] ACT_DRAIN   = 2'd2;

   // close causes
   localparam logic [1:0] CAUSE_EXPIRED = 2'd0;
   localparam logic [1:0] CAUSE_EVICTED = 2'd1;
   localparam logic [1:0] CAUSE_DRAINED = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] handle_id;
   } req_type;

   typedef struct packed {
      logic [31:0] closed_handle;
      logic [1:0]  close_cause;
      logic [3:0]  slot_number;
      logic        last_close;
   } rsp_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_GEN_INC,
      STEP_EXP_RET,
      STEP_PLACE,
      STEP_MIN_SCAN,
      STEP_EVICT,
      STEP_EXP_ADV,
      STEP_DRAIN,
      STEP_FLUSH
   } step_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_GEN_INC,
      OP_SCAN_EXPIRE,
      OP_SCAN_DRAIN,
      OP_SCAN_MIN,
      OP_PLACE,
      OP_EVICT,
      OP_FLUSH
   } op_type;

   typedef enum logic [1:0] {
      COND_DISPATCH,
      COND_ALWAYS,
      COND_SCAN_DONE,
      COND_FREE_SLOT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type next_true;
      step_type next_false;
   } ucode_type;

   typedef struct packed {
      logic scan_done;
      logic free_avail;
      logic handle_null;
   } status_type;

   // Microcode ROM: one control word per step.
   function automatic ucode_type ucode_word(input step_type s);
      ucode_type w;
      case (s)
         STEP_IDLE:     w = '{OP_NOP,         COND_DISPATCH,  STEP_IDLE,  STEP_IDLE};
         STEP_GEN_INC:  w = '{OP_GEN_INC,     COND_ALWAYS,    STEP_EXP_ADV, STEP_EXP_ADV};
         STEP_EXP_RET:  w = '{OP_SCAN_EXPIRE, COND_SCAN_DONE, STEP_PLACE, STEP_EXP_RET};
         STEP_PLACE:    w = '{OP_PLACE,       COND_FREE_SLOT, STEP_FLUSH, STEP_MIN_SCAN};
         STEP_MIN_SCAN: w = '{OP_SCAN_MIN,    COND_SCAN_DONE, STEP_EVICT, STEP_MIN_SCAN};
         STEP_EVICT:    w = '{OP_EVICT,       COND_ALWAYS,    STEP_FLUSH, STEP_FLUSH};
         STEP_EXP_ADV:  w = '{OP_SCAN_EXPIRE, COND_SCAN_DONE, STEP_FLUSH, STEP_EXP_ADV};
         STEP_DRAIN:    w = '{OP_SCAN_DRAIN,  COND_SCAN_DONE, STEP_FLUSH, STEP_DRAIN};
         STEP_FLUSH:    w = '{OP_FLUSH,       COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
         default:       w = '{OP_NOP,         COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### hdl/generational_retire_ring.sv
// ----------------------------------------------------------------------------
// generational_retire_ring
// Parks retired handle tokens in a ring of slots and closes them by age,
// by eviction when full, or on drain.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_data (action, handle_id) and raise start; the beat is
//   taken on a rising edge with start high and busy low. Retire of the null
//   token and the unused action code are taken and do nothing.
//   Response: every close shows on rsp_data for one cycle with rsp_valid
//   high; last_close marks the final close of a request. The receiver has
//   no back-pressure: sample every rsp_valid beat.
//   Config: csr_data carries grace_generations, written on csr_valid and
//   csr_ready high; csr_ready is high only while idle.
// Sequencing:
//   A microcode sequencer walks the slot memory one slot per cycle through a
//   registered read port. Advance bumps the generation, scans for expiry,
//   flushes; drain scans, flushes; retire scans for expiry, then fills a free
//   slot or, if full, scans for the oldest stamp and evicts, then flushes.
//   The next beat is taken at the end of the first cycle with busy low; null
//   retire and the unused code leave busy low. Each close is held one stage
//   so the final one can carry last_close: it shows the cycle after the next
//   close is found or after the flush step, so the final close shows in the
//   first cycle with busy low.
// Reset: all slots free, generation zero, grace 2; no clearing pass needed.
// ----------------------------------------------------------------------------
module generational_retire_ring
   import grr_pkg::*;
#(
   parameter int SLOT_COUNT      = DEF_SLOT_COUNT,
   parameter int HANDLE_BITS     = DEF_HANDLE_BITS,
   parameter int GENERATION_BITS = DEF_GENERATION_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [GRACE_BITS-1:0] csr_data
);

   logic       accept;
   op_type     op;
   status_type status;

   // take a request beat only while the sequencer rests
   assign accept    = start && !busy;
   // config only lands between requests
   assign csr_ready = !busy;

   grr_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_data.action),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   grr_datapath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .HANDLE_BITS     (HANDLE_BITS),
      .GENERATION_BITS (GENERATION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .op        (op),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/grr_sequencer.sv
// ----------------------------------------------------------------------------
// grr_sequencer
// Step counter and microcode ROM; picks the next step from the control word.
// ----------------------------------------------------------------------------
module grr_sequencer
   import grr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] action,
   input  status_type status,
   output op_type     op,
   output logic       busy
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;

   assign word = ucode_word(step_ff);

   // next step
   always_comb begin
      step_in = step_ff;
      case (word.cond)
         COND_DISPATCH: begin
            if (accept) begin
               case (action)
                  ACT_RETIRE:  step_in = status.handle_null ? STEP_IDLE : STEP_EXP_RET;
                  ACT_ADVANCE: step_in = STEP_GEN_INC;
                  ACT_DRAIN:   step_in = STEP_DRAIN;
                  default:     step_in = STEP_IDLE;
               endcase
            end
         end
         COND_ALWAYS:    step_in = word.next_true;
         COND_SCAN_DONE: step_in = status.scan_done ? word.next_true : word.next_false;
         COND_FREE_SLOT: step_in = status.free_avail ? word.next_true : word.next_false;
         default:        step_in = STEP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op   = word.op;
      busy = (step_ff != STEP_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### hdl/grr_datapath.sv
// ----------------------------------------------------------------------------
// grr_datapath
// Slot memory, valid marks, scan pipe, oldest search and result staging.
// ----------------------------------------------------------------------------
module grr_datapath
   import grr_pkg::*;
#(
   parameter int SLOT_COUNT      = DEF_SLOT_COUNT,
   parameter int HANDLE_BITS     = DEF_HANDLE_BITS,
   parameter int GENERATION_BITS = DEF_GENERATION_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req_data,
   input  logic                  csr_write,
   input  logic [GRACE_BITS-1:0] csr_data,
   input  op_type                op,
   output status_type            status,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam int IDX_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
   localparam int KEEP_W    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
   localparam int SLOT_KEEP = (IDX_W < 4) ? IDX_W : 4;
   localparam int AGE_W     = (GENERATION_BITS > GRACE_BITS) ? GENERATION_BITS : GRACE_BITS;
   localparam int ENTRY_W   = HANDLE_BITS + GENERATION_BITS;

   logic [ENTRY_W-1:0] mem [SLOT_COUNT];
   logic [ENTRY_W-1:0] rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   logic [GRACE_BITS-1:0]      grace_ff, grace_in;
   logic [GENERATION_BITS-1:0] gen_ff, gen_in;
   logic [HANDLE_BITS-1:0]     handle_ff, in_handle;
   logic [SLOT_COUNT-1:0]      valid_ff, valid_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]           p_idx_ff;

   logic [GENERATION_BITS-1:0] min_stamp_ff, min_stamp_in;
   logic [HANDLE_BITS-1:0]     min_handle_ff, min_handle_in;
   logic [IDX_W-1:0]           min_idx_ff, min_idx_in;

   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [HANDLE_BITS-1:0]     rd_handle;
   logic [GENERATION_BITS-1:0] rd_stamp;
   logic [GENERATION_BITS-1:0] age;
   logic                       age_ok;
   logic                       scanning;
   logic                       issue;
   logic [IDX_W-1:0]           first_free;
   logic                       free_avail;
   logic                       ev_valid;
   rsp_type                    ev;

   assign in_handle = HANDLE_BITS'(req_data.handle_id[KEEP_W-1:0]);
   assign rd_handle = rd_ff[ENTRY_W-1:GENERATION_BITS];
   assign rd_stamp  = rd_ff[GENERATION_BITS-1:0];
   assign age       = gen_ff - rd_stamp;
   assign age_ok    = (AGE_W'(age) >= AGE_W'(grace_ff));

   assign scanning = (op == OP_SCAN_EXPIRE) || (op == OP_SCAN_DRAIN) || (op == OP_SCAN_MIN);
   assign issue    = scanning && (cnt_ff < CNT_W'(SLOT_COUNT));
   assign rd_addr  = cnt_ff[IDX_W-1:0];

   // lowest free slot
   always_comb begin
      first_free = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            first_free = IDX_W'(i);
         end
      end
   end
   assign free_avail = ~&valid_ff;

   assign status.scan_done   = p_valid_ff && (p_idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign status.free_avail  = free_avail;
   assign status.handle_null = (in_handle == '0);

   // scan counter, close events, valid marks, generation
   always_comb begin
      cnt_in        = issue ? cnt_ff + CNT_W'(1) : (scanning ? cnt_ff : '0);
      p_valid_in    = issue;
      valid_in      = valid_ff;
      gen_in        = gen_ff;
      min_stamp_in  = min_stamp_ff;
      min_handle_in = min_handle_ff;
      min_idx_in    = min_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = first_free;
      ev_valid      = 1'b0;
      ev            = '0;
      case (op)
         OP_GEN_INC: gen_in = gen_ff + GENERATION_BITS'(1);
         OP_SCAN_EXPIRE: begin
            if (p_valid_ff && valid_ff[p_idx_ff] && age_ok) begin
               ev_valid           = 1'b1;
               ev.closed_handle   = 32'(rd_handle[KEEP_W-1:0]);
               ev.close_cause     = CAUSE_EXPIRED;
               ev.slot_number     = 4'(p_idx_ff[SLOT_KEEP-1:0]);
               valid_in[p_idx_ff] = 1'b0;
            end
         end
         OP_SCAN_DRAIN: begin
            if (p_valid_ff && valid_ff[p_idx_ff]) begin
               ev_valid           = 1'b1;
               ev.closed_handle   = 32'(rd_handle[KEEP_W-1:0]);
               ev.close_cause     = CAUSE_DRAINED;
               ev.slot_number     = 4'(p_idx_ff[SLOT_KEEP-1:0]);
               valid_in[p_idx_ff] = 1'b0;
            end
         end
         OP_SCAN_MIN: begin
            // first slot seeds the search; strict compare keeps the lowest index
            if (p_valid_ff && ((p_idx_ff == '0) || (rd_stamp < min_stamp_ff))) begin
               min_stamp_in  = rd_stamp;
               min_handle_in = rd_handle;
               min_idx_in    = p_idx_ff;
            end
         end
         OP_PLACE: begin
            if (free_avail) begin
               wr_en                = 1'b1;
               valid_in[first_free] = 1'b1;
            end
         end
         OP_EVICT: begin
            ev_valid         = 1'b1;
            ev.closed_handle = 32'(min_handle_ff[KEEP_W-1:0]);
            ev.close_cause   = CAUSE_EVICTED;
            ev.slot_number   = 4'(min_idx_ff[SLOT_KEEP-1:0]);
            wr_en            = 1'b1;
            wr_addr          = min_idx_ff;
         end
         default: ;
      endcase
   end

   // Hold one close back so the final one can carry the last flag.
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_in        = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (ev_valid) begin
         rsp_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_in       = ev;
      end else if ((op == OP_FLUSH) && pend_valid_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_in.last_close = 1'b1;
         pend_valid_in     = 1'b0;
      end
   end

   assign grace_in = csr_write ? csr_data : grace_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {handle_ff, gen_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff      <= GRACE_RESET;
         gen_ff        <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         p_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         grace_ff      <= grace_in;
         gen_ff        <= gen_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         p_valid_ff    <= p_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         handle_ff <= in_handle;
      end
      p_idx_ff      <= rd_addr;
      min_stamp_ff  <= min_stamp_in;
      min_handle_ff <= min_handle_in;
      min_idx_ff    <= min_idx_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### test/tb_generational_retire_ring.sv
// ----------------------------------------------------------------------------
// tb_generational_retire_ring
// Self-checking bench for the retire ring. A scoreboard keeps its own copy
// of the slots, the generation and the grace setting, predicts every close
// for each accepted request beat, and compares each close strobe, field by
// field, against the oldest predicted close. Directed beats cover the
// corner cases. Random phases at several grace settings then follow, with
// bursty request traffic.
// ----------------------------------------------------------------------------
module tb_generational_retire_ring
   import grr_pkg::*;
();

   localparam int SLOTS = DEF_SLOT_COUNT;
   // Action code that the block takes and ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // Idle cycles before a grace write or the final verdict: covers a full
   // retire-with-eviction pass plus the response trail through the held close
   localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
   localparam int DRAIN_WAIT_LIMIT = 400;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the ring and holds the closes still to come
   // -------------------------------------------------------------------------
   class retire_ring_scoreboard;
      bit        slot_taken [SLOTS];
      bit [31:0] slot_handle [SLOTS];
      bit [31:0] slot_stamp [SLOTS];
      bit [31:0] generation;
      bit [15:0] grace;
      rsp_type   step_closes [$];
      rsp_type   pending_closes [$];
      int        mismatches;

      function new();
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         generation = '0;
         grace = GRACE_RESET;
         mismatches = 0;
      endfunction

      function void close_slot(int s, logic [1:0] cause);
         rsp_type c;
         c.closed_handle = slot_handle[s];
         c.close_cause = cause;
         c.slot_number = s[3:0];
         c.last_close = 1'b0;
         step_closes.push_back(c);
         slot_taken[s] = 1'b0;
      endfunction

      // Age wraps with the generation counter
      function void expire_aged();
         for (int s = 0; s < SLOTS; s++) begin
            if (slot_taken[s] && (generation - slot_stamp[s]) >= {16'd0, grace})
               close_slot(s, CAUSE_EXPIRED);
         end
      endfunction

      function void note_request(req_type r);
         int dest;
         step_closes.delete();
         case (r.action)
            ACT_RETIRE: begin
               if (r.handle_id != '0) begin
                  expire_aged();
                  dest = -1;
                  for (int s = SLOTS - 1; s >= 0; s--) begin
                     if (!slot_taken[s]) dest = s;
                  end
                  // Full ring: evict the smallest raw stamp, lowest slot on a tie
                  if (dest < 0) begin
                     dest = 0;
                     for (int s = 1; s < SLOTS; s++) begin
                        if (slot_stamp[s] < slot_stamp[dest]) dest = s;
                     end
                     close_slot(dest, CAUSE_EVICTED);
                  end
                  slot_taken[dest] = 1'b1;
                  slot_handle[dest] = r.handle_id;
                  slot_stamp[dest] = generation;
               end
            end
            ACT_ADVANCE: begin
               generation = generation + 1;
               expire_aged();
            end
            ACT_DRAIN: begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (slot_taken[s]) close_slot(s, CAUSE_DRAINED);
               end
            end
            default: begin
            end
         endcase
         if (step_closes.size() > 0)
            step_closes[step_closes.size() - 1].last_close = 1'b1;
         foreach (step_closes[i]) pending_closes.push_back(step_closes[i]);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("   expected handle %h cause %0d slot %0d last %0b",
                     want.closed_handle, want.close_cause, want.slot_number,
                     want.last_close);
            $display("   actual   handle %h cause %0d slot %0d last %0b",
                     got.closed_handle, got.close_cause, got.slot_number,
                     got.last_close);
         end
      endfunction

      function void check_close(rsp_type got);
         rsp_type want;
         if (pending_closes.size() == 0) begin
            report("close with nothing pending", '0, got);
         end else begin
            want = pending_closes.pop_front();
            if (got.closed_handle !== want.closed_handle ||
                got.close_cause !== want.close_cause ||
                got.slot_number !== want.slot_number ||
                got.last_close !== want.last_close)
               report("close mismatch", want, got);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [GRACE_BITS-1:0] csr_data = '0;

   retire_ring_scoreboard ledger = new();
   int                    burst_left = 0;

   always #5 clock = ~clock;

   generational_retire_ring u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Sample every close strobe; the receiver cannot hold results off
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_close(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Driver tasks; each is entered right after a rising edge
   // -------------------------------------------------------------------------

   // Raise start with the beat and hold until busy is low at an edge
   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_request(r);
   endtask

   // Drop start for a gap of the given length
   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Send in bursts: back-to-back beats keep start high, gaps fall in between
   task automatic issue(input req_type r);
      if (burst_left == 0) begin
         pause_sender($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24)
                                                  : $urandom_range(1, 8);
      end
      send_request(r);
      burst_left--;
   endtask

   // Drop start, wait out pending closes, then idle through any silent pass
   task automatic settle();
      start <= 1'b0;
      burst_left = 0;
      for (int w = 0; w < DRAIN_WAIT_LIMIT && ledger.pending_closes.size() != 0; w++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_grace(input logic [GRACE_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      ledger.grace = value;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(logic [1:0] action, logic [31:0] handle);
      req_type r;
      r.action = action;
      r.handle_id = handle;
      return r;
   endfunction

   // Nonzero handle, weighted toward small values and toward high bits set
   function automatic logic [31:0] random_handle();
      logic [31:0] h;
      case ($urandom_range(0, 3))
         0: h = $urandom_range(1, 255);
         1: h = ~$urandom_range(0, 255);
         default: h = $urandom();
      endcase
      if (h == '0) h = 32'd1;
      return h;
   endfunction

   // One random phase; ignored beats (null retire, unused action) not counted
   task automatic run_phase(input logic [GRACE_BITS-1:0] g, input int n_items,
                            input int retire_pct, input int drain_pct);
      int done;
      int pick;
      req_type r;
      write_grace(g);
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(0, 99);
         r.handle_id = random_handle();
         if (pick < retire_pct) begin
            r.action = ACT_RETIRE;
            done++;
         end else if (pick < 94 - drain_pct) begin
            r.action = ACT_ADVANCE;
            done++;
         end else if (pick < 94) begin
            r.action = ACT_DRAIN;
            done++;
         end else if (pick < 97) begin
            r.action = ACT_RETIRE;
            r.handle_id = '0;
         end else begin
            r.action = ACT_UNUSED;
         end
         issue(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset grace of two: extreme handles, ignored beats, expiry by age
      issue(make_req(ACT_RETIRE, 32'hFFFF_FFFF));
      issue(make_req(ACT_RETIRE, 32'h0000_0001));
      issue(make_req(ACT_RETIRE, 32'h0000_0000));     // null token
      issue(make_req(ACT_UNUSED, 32'hA5A5_5A5A));     // unused action code
      issue(make_req(ACT_ADVANCE, 32'h5A5A_A5A5));    // age one: nothing closes
      issue(make_req(ACT_ADVANCE, 32'h0000_0000));    // age two: both expire
      issue(make_req(ACT_DRAIN, 32'hFFFF_FFFF));      // drain of an empty ring
      issue(make_req(ACT_RETIRE, 32'h8000_0000));
      issue(make_req(ACT_RETIRE, 32'h7FFF_FFFF));
      issue(make_req(ACT_DRAIN, 32'h0000_0000));

      // Zero grace: a handle parked in this generation expires on next retire
      write_grace(16'd0);
      issue(make_req(ACT_RETIRE, 32'h0000_00FF));
      issue(make_req(ACT_RETIRE, 32'h1234_5678));
      issue(make_req(ACT_ADVANCE, 32'h0000_0000));

      // Random phases; the widest grace with rare drains fills the ring and
      // forces evictions, including stamp ties
      run_phase(16'hFFFF, 40, 70, 2);
      run_phase(16'd0, 18, 55, 7);
      run_phase(16'd1, 18, 55, 7);
      run_phase(16'd3, 18, 60, 4);
      run_phase(GRACE_BITS'($urandom_range(4, 12)), 18, 60, 4);
      run_phase(16'd2, 14, 55, 7);
      run_phase(GRACE_BITS'($urandom_range(0, 65535)), 14, 65, 3);

      settle();
      if (ledger.mismatches == 0 && ledger.pending_closes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
